FILE: rtl/core/rab_pkg.sv
// shared constants, types and widths for the rgba over blender
package rab_pkg;

    localparam int CH_W     = 8;
    localparam int NCH      = 3;
    localparam int MUL_W    = 2 * CH_W;
    localparam int DT_W     = CH_W + MUL_W;
    localparam int NUM_W    = MUL_W + 1;
    localparam int REM_W    = MUL_W;
    localparam int RECIP_W  = 25;
    localparam int RECIP_SH = 32;
    localparam int FRONT_ST = 4;
    localparam int DIV_ST   = CH_W;
    localparam int PIPE_ST  = FRONT_ST + DIV_ST;

    localparam logic [CH_W-1:0]    FULL  = 8'd255;
    localparam logic [RECIP_W-1:0] RECIP = 25'd16843010;

    typedef logic [CH_W-1:0] chan_t;

    typedef struct packed {
        logic [NCH-1:0][NUM_W-1:0] num;
        chan_t                     oa;
    } mid_t;

    typedef struct packed {
        logic             byp;
        logic             wb;
        logic [NCH-1:0][CH_W-1:0] col;
        chan_t            alpha;
    } side_t;

endpackage

FILE: rtl/core/rgba_alpha_blend_over.sv
// top level: non-premultiplied rgba over compositor with valid/ready channels
//
// Takes one source and one destination pixel per item and returns the blended
// pixel. One item can be accepted every clock while a stage is free; each item
// passes 4 multiply stages, then an 8-stage divider giving one quotient bit per
// stage. Each stage holds its item when the next one is full and cannot move on,
// so a stall at the output backs up only as far as the first empty stage and
// input stays open while any stage is free. An opaque source passes straight
// through with write_back set; a transparent one returns the destination with
// write_back clear.
module rgba_alpha_blend_over (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rab_pkg::chan_t src_red,
    input  rab_pkg::chan_t src_green,
    input  rab_pkg::chan_t src_blue,
    input  rab_pkg::chan_t src_alpha,
    input  rab_pkg::chan_t dst_red,
    input  rab_pkg::chan_t dst_green,
    input  rab_pkg::chan_t dst_blue,
    input  rab_pkg::chan_t dst_alpha,
    output logic           out_valid,
    input  logic           out_ready,
    output rab_pkg::chan_t out_red,
    output rab_pkg::chan_t out_green,
    output rab_pkg::chan_t out_blue,
    output rab_pkg::chan_t out_alpha,
    output logic           write_back
);
    import rab_pkg::*;

    logic [PIPE_ST-1:0]       vld_reg;
    logic [PIPE_ST-1:0]       vld_next;
    logic [PIPE_ST-1:0]       en;
    side_t                    side_reg [PIPE_ST];
    side_t                    side_in;
    logic [NCH-1:0][CH_W-1:0] src_col;
    logic [NCH-1:0][CH_W-1:0] dst_col;
    logic [NCH-1:0][CH_W-1:0] quo;
    mid_t                     mid;
    chan_t                    oa;
    logic                     opaque;
    logic                     clear;

    assign src_col = {src_blue, src_green, src_red};
    assign dst_col = {dst_blue, dst_green, dst_red};

    // a stage loads when it is empty or its item moves on
    always_comb
    begin
        en[PIPE_ST-1] = !vld_reg[PIPE_ST-1] || out_ready;
        for (int i = PIPE_ST - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < PIPE_ST; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // bypass info for opaque and transparent sources
    assign opaque = src_alpha == FULL;
    assign clear  = src_alpha == '0;

    always_comb
    begin
        side_in.byp   = opaque || clear;
        side_in.wb    = !clear;
        side_in.col   = opaque ? src_col : dst_col;
        side_in.alpha = opaque ? FULL : dst_alpha;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= side_in;
        end
        for (int i = 1; i < PIPE_ST; i++)
        begin
            if (en[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    rab_front u_front (
        .clk       (clk),
        .en        (en[FRONT_ST-1:0]),
        .src_col   (src_col),
        .src_alpha (src_alpha),
        .dst_col   (dst_col),
        .dst_alpha (dst_alpha),
        .mid       (mid)
    );

    rab_div u_div (
        .clk (clk),
        .en  (en[PIPE_ST-1:FRONT_ST]),
        .mid (mid),
        .quo (quo),
        .oa  (oa)
    );

    assign out_valid  = vld_reg[PIPE_ST-1];
    assign out_red    = side_reg[PIPE_ST-1].byp ? side_reg[PIPE_ST-1].col[0] : quo[0];
    assign out_green  = side_reg[PIPE_ST-1].byp ? side_reg[PIPE_ST-1].col[1] : quo[1];
    assign out_blue   = side_reg[PIPE_ST-1].byp ? side_reg[PIPE_ST-1].col[2] : quo[2];
    assign out_alpha  = side_reg[PIPE_ST-1].byp ? side_reg[PIPE_ST-1].alpha : oa;
    assign write_back = side_reg[PIPE_ST-1].wb;

    a_ready_follows_out : assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output drains");

    a_bubble_opens_input : assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> in_ready)
        else $error("input blocked with empty first stage");

    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    a_nowrite_is_bypass : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_back |-> side_reg[PIPE_ST-1].byp)
        else $error("write_back clear on a blended item");

    a_stall_holds_last : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("stalled item dropped from last stage");

endmodule

FILE: rtl/core/rab_front.sv
// multiply stages: output alpha and per channel blend numerators
module rab_front (
    input  logic                                      clk,
    input  logic [rab_pkg::FRONT_ST-1:0]              en,
    input  logic [rab_pkg::NCH-1:0][rab_pkg::CH_W-1:0] src_col,
    input  rab_pkg::chan_t                            src_alpha,
    input  logic [rab_pkg::NCH-1:0][rab_pkg::CH_W-1:0] dst_col,
    input  rab_pkg::chan_t                            dst_alpha,
    output rab_pkg::mid_t                             mid
);
    import rab_pkg::*;

    // stage 1
    logic [MUL_W-1:0]           t1_reg;
    logic [NCH-1:0][MUL_W-1:0]  ss1_reg;
    logic [NCH-1:0][CH_W-1:0]   d1_reg;
    chan_t                      sa1_reg;
    // stage 2
    logic [CH_W-1:0]            ta2_reg;
    logic [NCH-1:0][DT_W-1:0]   dt2_reg;
    logic [NCH-1:0][MUL_W-1:0]  ss2_reg;
    chan_t                      sa2_reg;
    // stage 3
    logic [NCH-1:0][MUL_W-1:0]  dq3_reg;
    logic [NCH-1:0][MUL_W-1:0]  ss3_reg;
    chan_t                      oa3_reg;
    // stage 4
    logic [NCH-1:0][NUM_W-1:0]  num4_reg;
    chan_t                      oa4_reg;

    chan_t                          ia;
    logic [MUL_W+RECIP_W-1:0]       ta_prod;
    logic [NCH-1:0][DT_W+RECIP_W-1:0] dq_prod;
    logic [CH_W:0]                  oa_sum;

    assign ia      = FULL - src_alpha;
    assign ta_prod = {{RECIP_W{1'b0}}, t1_reg} * {{MUL_W{1'b0}}, RECIP};
    assign oa_sum  = {1'b0, sa2_reg} + {1'b0, ta2_reg};

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            dq_prod[c] = {{RECIP_W{1'b0}}, dt2_reg[c]} * {{DT_W{1'b0}}, RECIP};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t1_reg  <= {{CH_W{1'b0}}, dst_alpha} * {{CH_W{1'b0}}, ia};
            sa1_reg <= src_alpha;
            for (int c = 0; c < NCH; c++)
            begin
                ss1_reg[c] <= {{CH_W{1'b0}}, src_col[c]} * {{CH_W{1'b0}}, src_alpha};
                d1_reg[c]  <= dst_col[c];
            end
        end
        if (en[1])
        begin
            // t / 255 by reciprocal
            ta2_reg <= ta_prod[RECIP_SH+CH_W-1:RECIP_SH];
            sa2_reg <= sa1_reg;
            for (int c = 0; c < NCH; c++)
            begin
                dt2_reg[c] <= {{MUL_W{1'b0}}, d1_reg[c]} * {{CH_W{1'b0}}, t1_reg};
                ss2_reg[c] <= ss1_reg[c];
            end
        end
        if (en[2])
        begin
            oa3_reg <= oa_sum[CH_W-1:0];
            for (int c = 0; c < NCH; c++)
            begin
                dq3_reg[c] <= dq_prod[c][RECIP_SH+MUL_W-1:RECIP_SH];
                ss3_reg[c] <= ss2_reg[c];
            end
        end
        if (en[3])
        begin
            oa4_reg <= oa3_reg;
            for (int c = 0; c < NCH; c++)
            begin
                num4_reg[c] <= {1'b0, ss3_reg[c]} + {1'b0, dq3_reg[c]};
            end
        end
    end

    assign mid.num = num4_reg;
    assign mid.oa  = oa4_reg;

endmodule

FILE: rtl/core/rab_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating at 255
module rab_div (
    input  logic                                        clk,
    input  logic [rab_pkg::DIV_ST-1:0]                  en,
    input  rab_pkg::mid_t                               mid,
    output logic [rab_pkg::NCH-1:0][rab_pkg::CH_W-1:0]  quo,
    output rab_pkg::chan_t                              oa
);
    import rab_pkg::*;

    logic [DIV_ST-1:0][NCH-1:0][REM_W-1:0] rem_reg;
    logic [DIV_ST-1:0][NCH-1:0][CH_W-1:0]  q_reg;
    logic [DIV_ST-1:0][NCH-1:0]            sat_reg;
    chan_t                                 oa_reg [DIV_ST];

    genvar k;
    generate
        for (k = 0; k < DIV_ST; k++)
        begin : g_stage
            localparam int BIT = DIV_ST - 1 - k;

            logic [NCH-1:0][NUM_W-1:0] rem_in;
            logic [NCH-1:0][CH_W-1:0]  q_in;
            logic [NCH-1:0]            sat_in;
            chan_t                     oa_in;
            logic [NUM_W-1:0]          dsh;
            logic [NCH-1:0][NUM_W-1:0] rem_next;
            logic [NCH-1:0][CH_W-1:0]  q_next;

            if (k == 0)
            begin : g_first
                assign oa_in = mid.oa;
                always_comb
                begin
                    for (int c = 0; c < NCH; c++)
                    begin
                        rem_in[c] = mid.num[c];
                        q_in[c]   = '0;
                        sat_in[c] = mid.num[c] >= {1'b0, mid.oa, {CH_W{1'b0}}};
                    end
                end
            end
            else
            begin : g_next
                assign oa_in = oa_reg[k-1];
                always_comb
                begin
                    for (int c = 0; c < NCH; c++)
                    begin
                        rem_in[c] = {1'b0, rem_reg[k-1][c]};
                        q_in[c]   = q_reg[k-1][c];
                        sat_in[c] = sat_reg[k-1][c];
                    end
                end
            end

            assign dsh = {{(NUM_W-CH_W){1'b0}}, oa_in} << BIT;

            always_comb
            begin
                for (int c = 0; c < NCH; c++)
                begin
                    rem_next[c] = rem_in[c];
                    q_next[c]   = q_in[c];
                    if (rem_in[c] >= dsh)
                    begin
                        rem_next[c]  = rem_in[c] - dsh;
                        q_next[c][BIT] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    oa_reg[k] <= oa_in;
                    for (int c = 0; c < NCH; c++)
                    begin
                        rem_reg[k][c] <= rem_next[c][REM_W-1:0];
                        q_reg[k][c]   <= q_next[c];
                        sat_reg[k][c] <= sat_in[c];
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            quo[c] = sat_reg[DIV_ST-1][c] ? FULL : q_reg[DIV_ST-1][c];
        end
    end

    assign oa = oa_reg[DIV_ST-1];

endmodule
